### rtl/core/oaat_pkg.sv
// Shared types, constants and hash functions for the one-at-a-time bucket hash block.
`default_nettype none

package oaat_pkg;

  localparam int unsigned KeyW    = 8;
  localparam int unsigned HashW   = 32;
  localparam int unsigned SizeW   = 24;
  localparam int unsigned StepCntW = $clog2(HashW);

  localparam int unsigned ShMixAdd  = 10;
  localparam int unsigned ShMixXor  = 6;
  localparam int unsigned ShFinAdd1 = 3;
  localparam int unsigned ShFinXor  = 11;
  localparam int unsigned ShFinAdd2 = 15;

  localparam logic [SizeW-1:0] TableSizeReset = SizeW'(127);

  typedef enum logic [1:0] {
    ST_MIX,
    ST_FIN,
    ST_DIV,
    ST_DONE
  } oaat_state_e;

  typedef struct packed {
    logic fold;      // fold the accepted key byte into the running hash
    logic fin;       // apply avalanche, clear running hash, start divider
    logic div_step;  // one restoring-division step
    logic load_out;  // move result into the output register
  } oaat_cmd_t;

  typedef struct packed {
    logic div_last;  // current step is the last division step
  } oaat_status_t;

  function automatic logic [HashW-1:0] fold_byte(input logic [HashW-1:0] h,
                                                 input logic [KeyW-1:0]  b);
    logic [HashW-1:0] t;
    t = h + HashW'(b);
    t = t + (t << ShMixAdd);
    t = t ^ (t >> ShMixXor);
    return t;
  endfunction

  function automatic logic [HashW-1:0] avalanche(input logic [HashW-1:0] h);
    logic [HashW-1:0] t;
    t = h + (h << ShFinAdd1);
    t = t ^ (t >> ShFinXor);
    t = t + (t << ShFinAdd2);
    return t;
  endfunction

endpackage

`default_nettype wire

### rtl/core/one_at_a_time_bucket_hash_top.sv
// Top level of the one-at-a-time bucket hash: config register, controller and datapath.
// Flow: a non-last key byte is folded in the cycle it is accepted; after the last byte
//   input stalls through avalanche, 32 division steps and the load of the result word.
// The 32-step bit-serial remainder unit sets the per-key overhead. Bytes of the next key
//   are taken while a result waits in the output register, not while it waits to load.
// Reset: running hash clears to zero, table_size to 127, no result pending.
`default_nettype none

module one_at_a_time_bucket_hash_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [oaat_pkg::SizeW-1:0]  cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [oaat_pkg::KeyW-1:0]   key_byte_i,
  input  wire logic                        last_byte_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [oaat_pkg::HashW-1:0]       raw_hash_o,
  output logic [oaat_pkg::SizeW-1:0]       bucket_index_o
);
  import oaat_pkg::*;

  logic [SizeW-1:0] table_size_q;
  oaat_cmd_t        cmd;
  oaat_status_t     status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TableSizeReset;
    end else if (cfg_we_i) begin
      table_size_q <= cfg_wdata_i;
    end
  end

  oaat_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_byte_i (last_byte_i),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  oaat_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .key_byte_i     (key_byte_i),
    .table_size_i   (table_size_q),
    .raw_hash_o     (raw_hash_o),
    .bucket_index_o (bucket_index_o)
  );

  // hold off input after the last byte of a key
  a_stall_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && last_byte_i) |=> in_stall_o)
    else $error("input not stalled after last byte");

  // a new result only appears out of the finish sequence
  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.load_out) |-> in_stall_o)
    else $error("result loaded outside finish state");

  a_bucket_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (table_size_q != '0)) |-> (bucket_index_o < table_size_q))
    else $error("bucket index not below table size");

  a_fold_only_when_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.fold |-> (!cmd.fin && !cmd.div_step && !cmd.load_out))
    else $error("byte folded during finish sequence");

endmodule

`default_nettype wire

### rtl/core/oaat_ctrl.sv
// Controller state machine: byte acceptance, finish sequencing and output handshake.
`default_nettype none

module oaat_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  input  wire logic                  last_byte_i,
  output logic                       in_stall_o,
  input  wire logic                  out_stall_i,
  output logic                       out_valid_o,
  input  wire oaat_pkg::oaat_status_t status_i,
  output oaat_pkg::oaat_cmd_t        cmd_o
);
  import oaat_pkg::*;

  oaat_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        in_acc;
  logic        out_free;

  assign in_acc   = in_valid_i && (state_q == ST_MIX);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_MIX: begin
        if (in_acc && last_byte_i) state_d = ST_FIN;
      end
      ST_FIN: state_d = ST_DIV;
      ST_DIV: begin
        if (status_i.div_last) state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_MIX;
      end
      default: state_d = ST_MIX;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.fold     = in_acc;
    cmd_o.fin      = (state_q == ST_FIN);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.load_out = (state_q == ST_DONE) && out_free;
    in_stall_o     = (state_q != ST_MIX);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_MIX;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/oaat_dp.sv
// Datapath: running hash, avalanche, bit-serial remainder unit and output registers.
`default_nettype none

module oaat_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire oaat_pkg::oaat_cmd_t         cmd_i,
  output oaat_pkg::oaat_status_t           status_o,
  input  wire logic [oaat_pkg::KeyW-1:0]   key_byte_i,
  input  wire logic [oaat_pkg::SizeW-1:0]  table_size_i,
  output logic [oaat_pkg::HashW-1:0]       raw_hash_o,
  output logic [oaat_pkg::SizeW-1:0]       bucket_index_o
);
  import oaat_pkg::*;

  logic [HashW-1:0]    hash_q, hash_d;
  logic [HashW-1:0]    raw_q;
  logic [HashW-1:0]    quo_q;
  logic [SizeW-1:0]    rem_q;
  logic [StepCntW-1:0] cnt_q;
  logic [HashW-1:0]    fin_hash;
  logic [SizeW:0]      trial;
  logic [SizeW:0]      divisor;
  logic [SizeW-1:0]    rem_d;
  logic [HashW-1:0]    out_raw_q;
  logic [SizeW-1:0]    out_bucket_q;

  assign fin_hash = avalanche(hash_q);
  assign divisor  = {1'b0, table_size_i};
  assign trial    = {rem_q, quo_q[HashW-1]};

  always_comb begin
    if (trial >= divisor) begin
      rem_d = SizeW'(trial - divisor);
    end else begin
      rem_d = trial[SizeW-1:0];
    end
  end

  always_comb begin
    hash_d = hash_q;
    if (cmd_i.fold) begin
      hash_d = fold_byte(hash_q, key_byte_i);
    end else if (cmd_i.fin) begin
      hash_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= '0;
    end else begin
      hash_q <= hash_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      raw_q <= fin_hash;
      quo_q <= fin_hash;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= quo_q << 1;
      rem_q <= rem_d;
      cnt_q <= cnt_q + StepCntW'(1);
    end
    if (cmd_i.load_out) begin
      out_raw_q    <= raw_q;
      // a zero-size table maps every key to bucket zero
      out_bucket_q <= (table_size_i == '0) ? '0 : rem_q;
    end
  end

  assign status_o.div_last = (cnt_q == StepCntW'(HashW - 1));
  assign raw_hash_o        = out_raw_q;
  assign bucket_index_o    = out_bucket_q;

endmodule

`default_nettype wire

### dv/tb.sv
// Self-checking testbench for the one-at-a-time bucket hash block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DrainCycles = 40;
  localparam int NumPhases   = 8;
  localparam int PhaseBytes  = 80;
  localparam int HoldCycles  = 300;
  localparam int MaxReports  = 10;

  // Key words for the directed part: {last, byte}.
  localparam logic [8:0] DIRECTED [17] = '{
    9'h100, 9'h1FF,                          // single-byte keys, both extremes
    9'h000, 9'h000, 9'h100,                  // zero bytes do not end a key
    9'h0FF, 9'h0FF, 9'h0FF, 9'h1FF,          // all ones
    9'h061, 9'h062, 9'h163,                  // "abc"
    9'h080, 9'h001, 9'h17F,
    9'h055, 9'h1AA
  };

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_BURSTY
  } stall_mode_e;

  typedef struct packed {
    logic [oaat_pkg::HashW-1:0] raw;
    logic [oaat_pkg::SizeW-1:0] bucket;
  } hash_result_t;

  class hash_scoreboard;
    logic [oaat_pkg::HashW-1:0] running_hash;
    logic [oaat_pkg::SizeW-1:0] table_size;
    hash_result_t               expected_q[$];
    int                         mismatches;
    int                         keys_checked;

    function new();
      running_hash = '0;
      table_size   = oaat_pkg::TableSizeReset;
      mismatches   = 0;
      keys_checked = 0;
    endfunction

    function logic [oaat_pkg::HashW-1:0] mix_key_byte(logic [oaat_pkg::HashW-1:0] h,
                                                      logic [oaat_pkg::KeyW-1:0] b);
      logic [oaat_pkg::HashW-1:0] m;
      m = h + {24'd0, b};
      m = m + (m << 10);
      return m ^ (m >> 6);
    endfunction

    function logic [oaat_pkg::HashW-1:0] finalize_hash(logic [oaat_pkg::HashW-1:0] h);
      logic [oaat_pkg::HashW-1:0] m;
      m = h + (h << 3);
      m = m ^ (m >> 11);
      return m + (m << 15);
    endfunction

    function void set_table_size(logic [oaat_pkg::SizeW-1:0] v);
      table_size = v;
    endfunction

    function void note_byte(logic [oaat_pkg::KeyW-1:0] b, logic last);
      hash_result_t r;
      running_hash = mix_key_byte(running_hash, b);
      if (last) begin
        r.raw        = finalize_hash(running_hash);
        // an empty table maps every key to bucket zero
        r.bucket     = (table_size == 0) ? '0 : oaat_pkg::SizeW'(r.raw % table_size);
        running_hash = '0;
        expected_q.push_back(r);
      end
    endfunction

    function void check_result(logic [oaat_pkg::HashW-1:0] raw,
                               logic [oaat_pkg::SizeW-1:0] bucket);
      hash_result_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected result word: raw %h bucket %h", raw, bucket);
        return;
      end
      e = expected_q.pop_front();
      keys_checked++;
      if (e.raw !== raw || e.bucket !== bucket) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("key %0d mismatch: raw exp %h got %h, bucket exp %h got %h",
                   keys_checked, e.raw, raw, e.bucket, bucket);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [oaat_pkg::SizeW-1:0] cfg_wdata_i = '0;
  logic                       in_valid_i = 1'b0;
  logic                       in_stall_o;
  logic [oaat_pkg::KeyW-1:0]  key_byte_i = '0;
  logic                       last_byte_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i = 1'b0;
  logic [oaat_pkg::HashW-1:0] raw_hash_o;
  logic [oaat_pkg::SizeW-1:0] bucket_index_o;

  hash_scoreboard sb = new();

  stall_mode_e stall_mode  = STALL_NONE;
  bit          idle_on     = 1'b0;
  int          burst_left  = 0;
  int          hold_cycles = 0;
  int          stall_run   = 0;
  bit          stall_flag  = 1'b0;
  int          bytes_sent  = 0;
  int          input_held  = 0;

  one_at_a_time_bucket_hash_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .key_byte_i    (key_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .raw_hash_o    (raw_hash_o),
    .bucket_index_o(bucket_index_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Result words: everything is stable at the falling edge, the word moves at the next rise.
  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(raw_hash_o, bucket_index_o);
  end

  // Receiver stall pattern; a requested hold-off overrides it.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else begin
        case (stall_mode)
          STALL_NONE: begin
            out_stall_i <= 1'b0;
          end
          STALL_RANDOM: begin
            out_stall_i <= ($urandom_range(0, 3) == 0);
          end
          default: begin
            if (stall_run == 0) begin
              stall_run  = $urandom_range(1, 12);
              stall_flag = !stall_flag;
            end
            stall_run--;
            out_stall_i <= stall_flag;
          end
        endcase
      end
    end
  end

  task automatic send_word(logic [oaat_pkg::KeyW-1:0] b, logic last);
    bit taken;
    if (idle_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    in_valid_i  <= 1'b1;
    key_byte_i  <= b;
    last_byte_i <= last;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      if (in_stall_o) input_held++;
      @(posedge clk_i);
    end while (!taken);
    sb.note_byte(b, last);
    bytes_sent++;
  endtask

  // Drop valid and wait for every outstanding hash to come back.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic write_table_size(logic [oaat_pkg::SizeW-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_table_size(v);
  endtask

  task automatic send_keys(int n_bytes, bit pause_mid);
    int sent;
    int len;
    int r;
    logic [oaat_pkg::KeyW-1:0] b;
    sent = 0;
    while (sent < n_bytes) begin
      if (pause_mid && sent >= n_bytes / 2) begin
        pause_mid = 1'b0;
        drain_results();
      end
      r = $urandom_range(0, 19);
      if (r < 16)      len = $urandom_range(1, 6);
      else if (r < 19) len = $urandom_range(7, 16);
      else             len = $urandom_range(17, 48);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(0, 9);
        if (r == 0)      b = 8'h00;
        else if (r == 1) b = 8'hFF;
        else             b = oaat_pkg::KeyW'($urandom_range(0, 255));
        send_word(b, i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    logic [oaat_pkg::SizeW-1:0] tsize;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (DIRECTED[i]) send_word(DIRECTED[i][7:0], DIRECTED[i][8]);
    for (int p = 0; p < NumPhases; p++) begin
      if (p > 0) begin
        drain_results();
        repeat (DrainCycles) @(posedge clk_i);
        case (p)
          1:       tsize = 24'd1;
          2:       tsize = 24'hFFFFFF;
          3:       tsize = 24'd0;
          4:       tsize = 24'd2;
          5:       tsize = 24'h800000;
          6:       tsize = oaat_pkg::SizeW'($urandom_range(3, 24'hFFFFFE));
          default: tsize = oaat_pkg::SizeW'($urandom_range(3, 300));
        endcase
        write_table_size(tsize);
      end
      idle_on    = (p % 3 != 2);
      burst_left = 0;
      stall_mode = (p % 3 == 0) ? STALL_NONE : (p % 3 == 1) ? STALL_RANDOM : STALL_BURSTY;
      // long hold-off with the sender running flat out: the block must back up
      if (p == 2) hold_cycles = HoldCycles;
      send_keys(PhaseBytes, p == 4);
    end
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending() != 0) begin
      $display("%0d hashes never came back", sb.pending());
      sb.mismatches += sb.pending();
    end
    $display("Covered %0d key bytes, %0d keys over %0d table sizes (1, max, 0, powers of 2).",
             bytes_sent, sb.keys_checked, NumPhases);
    $display("Input held back for %0d cycles; %0d mismatches.", input_held, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("timeout with %0d hashes outstanding", sb.pending());
    $display("FAILED: results differ");
    $finish;
  end

endmodule
